// File: hdl/sbc_pkg.sv
`default_nettype none

package sbc_pkg;

    // Storage and register widths
    localparam int DEFAULT_BUFFER_DEPTH = 512;
    localparam int CFG_LEN_W            = 9;
    localparam int CFG_MS_W             = 16;
    localparam int CFG_ADDR_W           = 4;
    localparam int CFG_DATA_W           = 32;
    localparam int OUT_LEN_W            = 10;

    // Register reset values
    localparam logic [CFG_LEN_W-1:0] MIN_CHUNK_RESET    = 9'd30;
    localparam logic [CFG_LEN_W-1:0] MAX_CHUNK_RESET    = 9'd200;
    localparam logic [CFG_MS_W-1:0]  MIN_INTERVAL_RESET = 16'd300;

    // Register map, indexed by word address
    typedef enum logic [1:0] {
        REG_MIN_CHUNK    = 2'd0,
        REG_MAX_CHUNK    = 2'd1,
        REG_MIN_INTERVAL = 2'd2
    } reg_index_t;

    // Input word kinds
    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_FLUSH = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    // Reasons a chunk is cut
    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_BOUNDARY = 2'd1,
        CAUSE_FORCED   = 2'd2,
        CAUSE_FLUSH    = 2'd3
    } cause_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       end_of_feed;
    } in_item_t;

    typedef struct packed {
        logic                 chunk_valid;
        logic [OUT_LEN_W-1:0] chunk_length;
        logic [1:0]           chunk_cause;
        logic                 byte_dropped;
        logic [OUT_LEN_W-1:0] pending_bytes;
    } out_item_t;

endpackage

`default_nettype wire

// File: hdl/sbc_ram.sv
`default_nettype none

module sbc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write one word, read one word with a registered output
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/sentence_boundary_chunker_core.sv
`default_nettype none

// Sentence boundary chunker. Text bytes, flush requests and millisecond ticks arrive as
// words on the s_ channel; every input word yields exactly one result word on the m_
// channel. Text is held in a ring buffer of BUFFER_DEPTH bytes in a single-port-read RAM.
// A tick or flush goes from the idle state straight to the done state, as does a text byte
// that starts no search. A byte marked end_of_feed (and not throttled) starts a scan of
// the buffer from its front, reading each byte in S_RD and checking it in S_CHK, stopping
// at the first boundary at or beyond min_chunk_bytes. With no boundary found and more than
// max_chunk_bytes buffered, a forced split walks back from max_chunk_bytes to a UTF-8 lead
// byte. The block takes no new word while it works on one, but accepts the next
// word while a finished result still waits for m_ready. Configuration is written over the
// APB port at byte addresses 0 (min_chunk_bytes), 4 (max_chunk_bytes) and 8
// (min_interval_ms); it must only be written while the block is idle.

module sentence_boundary_chunker_core #(
    parameter int BUFFER_DEPTH = sbc_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sbc_pkg::in_item_t               s_data,
    // Result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sbc_pkg::out_item_t                   m_data,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sbc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [sbc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    import sbc_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int LW = (CW > CFG_LEN_W) ? CW : CFG_LEN_W;
    localparam logic [LW:0]   DEPTH_SUM = (LW + 1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(BUFFER_DEPTH);

    localparam logic [7:0] UTF8_TOP_MASK = 8'hC0;
    localparam logic [7:0] UTF8_CONT     = 8'h80;
    localparam logic [7:0] WIDE_LEAD_A   = 8'hE3;
    localparam logic [7:0] WIDE_MID_A    = 8'h80;
    localparam logic [7:0] WIDE_END_A    = 8'h82;
    localparam logic [7:0] WIDE_LEAD_B   = 8'hEF;
    localparam logic [7:0] WIDE_MID_B    = 8'hBC;
    localparam logic [7:0] WIDE_EXCL     = 8'h81;
    localparam logic [7:0] WIDE_QUEST    = 8'h9F;
    localparam logic [7:0] WIDE_SEMI     = 8'h9B;
    localparam logic [7:0] WIDE_COLON    = 8'h9A;
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_EXCL       = 8'h21;
    localparam logic [7:0] CH_QUEST      = 8'h3F;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_DECIDE,
        S_BACK_RD,
        S_BACK_CHK,
        S_DONE
    } state_t;

    // Ring offset to RAM address; base + offset stays below twice the depth
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [LW-1:0] off);
        logic [LW:0] sum;
        begin
            sum = (LW + 1)'(base) + (LW + 1)'(off);
            if (sum >= DEPTH_SUM) begin
                sum = sum - DEPTH_SUM;
            end
            return sum[AW-1:0];
        end
    endfunction

    function automatic logic ascii_term(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_EXCL) || (c == CH_QUEST) || (c == CH_SEMI) ||
               (c == CH_COLON) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic wide_term(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2);
        logic hit_a;
        logic hit_b;
        begin
            hit_a = (b0 == WIDE_LEAD_A) && (b1 == WIDE_MID_A) && (b2 == WIDE_END_A);
            hit_b = (b0 == WIDE_LEAD_B) && (b1 == WIDE_MID_B) &&
                    ((b2 == WIDE_EXCL) || (b2 == WIDE_QUEST) ||
                     (b2 == WIDE_SEMI) || (b2 == WIDE_COLON));
            return hit_a || hit_b;
        end
    endfunction

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic                  emitted_reg, emitted_next;
    logic [CFG_MS_W-1:0]   ms_reg, ms_next;
    logic [CFG_LEN_W-1:0]  min_chunk_reg, min_chunk_next;
    logic [CFG_LEN_W-1:0]  max_chunk_reg, max_chunk_next;
    logic [CFG_MS_W-1:0]   interval_reg, interval_next;
    logic [LW-1:0]         idx_reg, idx_next;
    logic [LW-1:0]         best_reg, best_next;
    logic [LW-1:0]         cut_reg, cut_next;
    logic [7:0]            win1_reg, win1_next;
    logic [7:0]            win2_reg, win2_next;
    logic                  res_valid_reg, res_valid_next;
    logic [LW-1:0]         res_len_reg, res_len_next;
    cause_t                res_cause_reg, res_cause_next;
    logic                  res_drop_reg, res_drop_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [7:0]            ram_rdata;

    logic                  cfg_wr;
    logic                  throttled;
    logic                  room;
    logic [CW-1:0]         fill_inc;
    logic                  hit;
    logic [LW-1:0]         idx_inc;
    logic                  emit_go;
    logic [LW-1:0]         emit_len;
    cause_t                emit_cause;

    sbc_ram #(
        .DATA_W (8),
        .DEPTH  (BUFFER_DEPTH)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // APB side: always ready, reads return the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_MIN_CHUNK:    prdata = CFG_DATA_W'(min_chunk_reg);
            REG_MAX_CHUNK:    prdata = CFG_DATA_W'(max_chunk_reg);
            REG_MIN_INTERVAL: prdata = CFG_DATA_W'(interval_reg);
            default:          prdata = '0;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign throttled = emitted_reg && (ms_reg < interval_reg);
    assign room      = (fill_reg < DEPTH_CNT);
    assign fill_inc  = room ? fill_reg + CW'(1) : fill_reg;
    assign idx_inc   = idx_reg + LW'(1);
    assign ram_waddr = wrap_addr(head_reg, LW'(fill_reg));
    assign ram_raddr = (state_reg == S_RD) ? wrap_addr(head_reg, idx_reg)
                                           : wrap_addr(head_reg, cut_reg);

    // Boundary test on the byte just read, with the two before it for wide marks
    assign hit = ((ram_rdata < ASCII_LIMIT) && ascii_term(ram_rdata)) ||
                 ((idx_reg >= LW'(2)) && wide_term(win2_reg, win1_reg, ram_rdata));

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        emitted_next   = emitted_reg;
        ms_next        = ms_reg;
        min_chunk_next = min_chunk_reg;
        max_chunk_next = max_chunk_reg;
        interval_next  = interval_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        cut_next       = cut_reg;
        win1_next      = win1_reg;
        win2_next      = win2_reg;
        res_valid_next = res_valid_reg;
        res_len_next   = res_len_reg;
        res_cause_next = res_cause_reg;
        res_drop_next  = res_drop_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        emit_go        = 1'b0;
        emit_len       = cut_reg;
        emit_cause     = CAUSE_FORCED;

        // Drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_valid_next = 1'b0;
                    res_len_next   = '0;
                    res_cause_next = CAUSE_NONE;
                    res_drop_next  = 1'b0;
                    state_next     = S_DONE;
                    case (s_data.kind)
                        KIND_TEXT: begin
                            ram_we        = room;
                            fill_next     = fill_inc;
                            res_drop_next = !room;
                            if (s_data.end_of_feed && (fill_inc != '0) && !throttled) begin
                                idx_next   = '0;
                                best_next  = '0;
                                state_next = S_RD;
                            end
                        end
                        KIND_FLUSH: begin
                            if (fill_reg != '0) begin
                                res_valid_next = 1'b1;
                                res_len_next   = LW'(fill_reg);
                                res_cause_next = CAUSE_FLUSH;
                                head_next      = wrap_addr(head_reg, LW'(fill_reg));
                                fill_next      = '0;
                            end
                            emitted_next = 1'b0;
                        end
                        KIND_TICK: begin
                            if (ms_reg != '1) begin
                                ms_next = ms_reg + CFG_MS_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Issue the read of the next byte, or end the scan
            S_RD: begin
                if (idx_reg == LW'(fill_reg)) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_CHK;
                end
            end

            // Check the byte, advance the window
            S_CHK: begin
                win2_next  = win1_reg;
                win1_next  = ram_rdata;
                idx_next   = idx_inc;
                state_next = S_RD;
                if (hit) begin
                    best_next = idx_inc;
                    if (idx_inc >= LW'(min_chunk_reg)) begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                if (best_reg != '0) begin
                    emit_go    = 1'b1;
                    emit_len   = best_reg;
                    emit_cause = CAUSE_BOUNDARY;
                end else if ((LW'(fill_reg) > LW'(max_chunk_reg)) && (max_chunk_reg != '0)) begin
                    cut_next   = LW'(max_chunk_reg);
                    state_next = S_BACK_RD;
                end else begin
                    state_next = S_DONE;
                end
            end

            // Back off from the split point to a lead byte
            S_BACK_RD: begin
                if (cut_reg == '0) begin
                    emit_go  = 1'b1;
                    emit_len = LW'(max_chunk_reg);
                end else begin
                    state_next = S_BACK_CHK;
                end
            end

            S_BACK_CHK: begin
                if ((ram_rdata & UTF8_TOP_MASK) == UTF8_CONT) begin
                    cut_next   = cut_reg - LW'(1);
                    state_next = S_BACK_RD;
                end else begin
                    emit_go = 1'b1;
                end
            end

            // Hand the result to the output register when it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.chunk_valid   = res_valid_reg;
                    m_data_next.chunk_length  = OUT_LEN_W'(res_len_reg);
                    m_data_next.chunk_cause   = res_cause_reg;
                    m_data_next.byte_dropped  = res_drop_reg;
                    m_data_next.pending_bytes = OUT_LEN_W'(fill_reg);
                    state_next                = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Remove the chunk from the front of the ring
        if (emit_go) begin
            res_valid_next = 1'b1;
            res_len_next   = emit_len;
            res_cause_next = emit_cause;
            head_next      = wrap_addr(head_reg, emit_len);
            fill_next      = fill_reg - emit_len[CW-1:0];
            emitted_next   = 1'b1;
            ms_next        = '0;
            state_next     = S_DONE;
        end

        // Register writes
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_MIN_CHUNK:    min_chunk_next = pwdata[CFG_LEN_W-1:0];
                REG_MAX_CHUNK:    max_chunk_next = pwdata[CFG_LEN_W-1:0];
                REG_MIN_INTERVAL: interval_next  = pwdata[CFG_MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            emitted_reg   <= 1'b0;
            ms_reg        <= '0;
            min_chunk_reg <= MIN_CHUNK_RESET;
            max_chunk_reg <= MAX_CHUNK_RESET;
            interval_reg  <= MIN_INTERVAL_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            emitted_reg   <= emitted_next;
            ms_reg        <= ms_next;
            min_chunk_reg <= min_chunk_next;
            max_chunk_reg <= max_chunk_next;
            interval_reg  <= interval_next;
            m_valid_reg   <= m_valid_next;
        end
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        cut_reg       <= cut_next;
        win1_reg      <= win1_next;
        win2_reg      <= win2_next;
        res_valid_reg <= res_valid_next;
        res_len_reg   <= res_len_next;
        res_cause_reg <= res_cause_next;
        res_drop_reg  <= res_drop_next;
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire
